[rtl/oal_pkg.sv]
`timescale 1ns / 1ps

package oal_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned MODE_W         = 3;
  localparam int unsigned VALUE_W        = 32;

  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GET    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOCATE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PRIOR  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd6;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BADPOS,
    ST_FULL,
    ST_NOTFOUND
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_DRAIN,
    S_INS_WR,
    S_SHIFT_DN,
    S_RD_WAIT,
    S_RD_CAP,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    PTR_HOLD,
    PTR_INC,
    PTR_DEC,
    PTR_ZERO,
    PTR_CNT_M1,
    PTR_POS_M1,
    PTR_POS,
    PTR_PREV,
    PTR_NEXT
  } ptr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef struct packed {
    logic    load;
    ptr_op_t ptr_op;
    logic    wb_up;
    logic    wb_dn;
    logic    scan;
    logic    wr_val;
    logic    cap_data;
    logic    set_found;
    logic    set_status;
    status_t status;
    cnt_op_t cnt_op;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              ins_bad;
    logic              full;
    logic              ins_noshift;
    logic              rd_bad;
    logic              up_last;
    logic              dn_last;
    logic              del_noshift;
    logic              scan_hit;
    logic              scan_miss;
    logic              hit_first;
    logic              hit_last;
  } dp_stat_t;

endpackage

[rtl/oal_if.sv]
`timescale 1ns / 1ps

interface oal_in_if
  import oal_pkg::*;
#(
  parameter int unsigned POS_W = $clog2(CAPACITY_DEF + 1)
) ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface oal_out_if
  import oal_pkg::*;
#(
  parameter int unsigned POS_W = $clog2(CAPACITY_DEF + 1)
) ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [VALUE_W-1:0] data_out;
  logic [POS_W-1:0]          found_position;
  logic [POS_W-1:0]          list_length;

  modport source (output valid, status, data_out, found_position, list_length, input ready);
  modport sink   (input valid, status, data_out, found_position, list_length, output ready);
endinterface

[rtl/oal_ctrl.sv]
`timescale 1ns / 1ps

module oal_ctrl
  import oal_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.ptr_op = PTR_HOLD;
    cmd.cnt_op = CNT_HOLD;
    cmd.status = ST_OK;
    in_ready   = 1'b0;
    state_nxt  = state_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.mode) inside
          MODE_INSERT: begin
            if (stat.ins_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BADPOS;
              state_nxt      = S_DONE;
            end else if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
              state_nxt      = S_DONE;
            end else if (stat.ins_noshift) begin
              cmd.ptr_op = PTR_POS_M1;
              state_nxt  = S_INS_WR;
            end else begin
              cmd.ptr_op = PTR_CNT_M1;
              state_nxt  = S_SHIFT_UP;
            end
          end
          MODE_DELETE, MODE_GET: begin
            if (stat.rd_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BADPOS;
              state_nxt      = S_DONE;
            end else begin
              cmd.ptr_op = PTR_POS_M1;
              state_nxt  = S_RD_WAIT;
            end
          end
          MODE_LOCATE, MODE_PRIOR, MODE_NEXT: begin
            cmd.ptr_op = PTR_ZERO;
            state_nxt  = S_SCAN;
          end
          MODE_CLEAR: begin
            cmd.cnt_op = CNT_CLR;
            state_nxt  = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SHIFT_UP: begin
        cmd.wb_up = 1'b1;
        if (stat.up_last) begin
          cmd.ptr_op = PTR_POS_M1;
          state_nxt  = S_DRAIN;
        end else begin
          cmd.ptr_op = PTR_DEC;
        end
      end
      S_DRAIN: begin
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.wr_val = 1'b1;
        cmd.cnt_op = CNT_INC;
        state_nxt  = S_DONE;
      end
      S_RD_WAIT: begin
        cmd.ptr_op = PTR_POS;
        state_nxt  = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd.cap_data = 1'b1;
        if (stat.mode == MODE_DELETE) begin
          if (stat.del_noshift) begin
            cmd.cnt_op = CNT_DEC;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SHIFT_DN;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_DN: begin
        cmd.wb_dn  = 1'b1;
        cmd.ptr_op = PTR_INC;
        if (stat.dn_last) begin
          cmd.cnt_op = CNT_DEC;
          state_nxt  = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.ptr_op = PTR_INC;
        if (stat.scan_hit) begin
          cmd.set_found = 1'b1;
          if (stat.mode == MODE_PRIOR) begin
            if (stat.hit_first) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NOTFOUND;
              state_nxt      = S_DONE;
            end else begin
              cmd.ptr_op = PTR_PREV;
              state_nxt  = S_RD_WAIT;
            end
          end else if (stat.mode == MODE_NEXT) begin
            if (stat.hit_last) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NOTFOUND;
              state_nxt      = S_DONE;
            end else begin
              cmd.ptr_op = PTR_NEXT;
              state_nxt  = S_RD_WAIT;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end else if (stat.scan_miss) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOTFOUND;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted item did not move to decode");

  a_shift_dn_delete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_DN) |-> (stat.mode == MODE_DELETE))
    else $error("shift down outside delete");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside done");

endmodule

[rtl/oal_dp.sv]
`timescale 1ns / 1ps

module oal_dp
  import oal_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [MODE_W-1:0]         in_mode,
  input  logic [CW-1:0]             in_position,
  input  logic signed [VALUE_W-1:0] in_value,
  input  dp_cmd_t                   cmd,
  output dp_stat_t                  stat,
  output logic [1:0]                out_status,
  output logic signed [VALUE_W-1:0] out_data,
  output logic [CW-1:0]             out_found,
  output logic [CW-1:0]             out_length
);

  localparam int unsigned DW = DATA_WIDTH;

  logic [DW-1:0] mem [CAPACITY];
  logic [DW-1:0] rd_data_r;

  logic [MODE_W-1:0] req_mode_r;
  logic [CW-1:0]     req_pos_r;
  logic [DW-1:0]     req_val_r;
  logic [DW-1:0]     in_elem;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          wb_valid_r;
  logic [AW-1:0] wb_addr_r;
  logic [CW-1:0] wb_tgt;
  logic          cmp_valid_r;
  logic [CW-1:0] cmp_idx_r;

  status_t       status_r;
  logic [DW-1:0] data_r;
  logic [CW-1:0] found_r;

  logic [1:0]          out_status_r;
  logic [VALUE_W-1:0]  out_data_r;
  logic [VALUE_W-1:0]  data_ext;
  logic [CW-1:0]       out_found_r;
  logic [CW-1:0]       out_len_r;

  generate
    if (DW > VALUE_W) begin : g_wide
      assign in_elem  = {{(DW - VALUE_W){1'b0}}, in_value};
      assign data_ext = data_r[VALUE_W-1:0];
    end else if (DW == VALUE_W) begin : g_same
      assign in_elem  = in_value;
      assign data_ext = data_r;
    end else begin : g_narrow
      assign in_elem  = in_value[DW-1:0];
      assign data_ext = {{(VALUE_W - DW){1'b0}}, data_r};
    end
  endgenerate

  // element store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wb_valid_r) begin
      mem[wb_addr_r] <= rd_data_r;
    end else if (cmd.wr_val) begin
      mem[ptr_r[AW-1:0]] <= req_val_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[ptr_r[AW-1:0]];
  end

  always_comb begin
    unique case (cmd.ptr_op)
      PTR_HOLD:   ptr_nxt = ptr_r;
      PTR_INC:    ptr_nxt = ptr_r + CW'(1);
      PTR_DEC:    ptr_nxt = ptr_r - CW'(1);
      PTR_ZERO:   ptr_nxt = '0;
      PTR_CNT_M1: ptr_nxt = cnt_r - CW'(1);
      PTR_POS_M1: ptr_nxt = req_pos_r - CW'(1);
      PTR_POS:    ptr_nxt = req_pos_r;
      PTR_PREV:   ptr_nxt = cmp_idx_r - CW'(1);
      PTR_NEXT:   ptr_nxt = cmp_idx_r + CW'(1);
      default:    ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    unique case (cmd.cnt_op)
      CNT_HOLD: cnt_nxt = cnt_r;
      CNT_INC:  cnt_nxt = cnt_r + CW'(1);
      CNT_DEC:  cnt_nxt = cnt_r - CW'(1);
      CNT_CLR:  cnt_nxt = '0;
      default:  cnt_nxt = cnt_r;
    endcase
  end

  assign wb_tgt = cmd.wb_up ? (ptr_r + CW'(1)) : (ptr_r - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      wb_valid_r  <= 1'b0;
      cmp_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      wb_valid_r  <= cmd.wb_up || cmd.wb_dn;
      cmp_valid_r <= cmd.scan && (ptr_r < cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    wb_addr_r <= wb_tgt[AW-1:0];
    cmp_idx_r <= ptr_r;
    if (cmd.load) begin
      req_mode_r <= in_mode;
      req_pos_r  <= in_position;
      req_val_r  <= in_elem;
      status_r   <= ST_OK;
      data_r     <= '0;
      found_r    <= '0;
    end else begin
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      if (cmd.cap_data) begin
        data_r <= rd_data_r;
      end
      if (cmd.set_found) begin
        found_r <= cmp_idx_r + CW'(1);
      end
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_data_r   <= data_ext;
      out_found_r  <= found_r;
      out_len_r    <= cnt_r;
    end
  end

  always_comb begin
    stat.mode        = req_mode_r;
    stat.ins_bad     = (req_pos_r == '0) ||
                       ({1'b0, req_pos_r} > ({1'b0, cnt_r} + (CW + 1)'(1)));
    stat.full        = cnt_r >= CW'(CAPACITY);
    stat.ins_noshift = {1'b0, req_pos_r} == ({1'b0, cnt_r} + (CW + 1)'(1));
    stat.rd_bad      = (req_pos_r == '0) || (req_pos_r > cnt_r);
    stat.up_last     = ptr_r == (req_pos_r - CW'(1));
    stat.dn_last     = ptr_r == (cnt_r - CW'(1));
    stat.del_noshift = req_pos_r == cnt_r;
    stat.scan_hit    = cmp_valid_r && (rd_data_r == req_val_r);
    stat.scan_miss   = !cmp_valid_r && (ptr_r >= cnt_r);
    stat.hit_first   = cmp_idx_r == '0;
    stat.hit_last    = ({1'b0, cmp_idx_r} + (CW + 1)'(1)) >= {1'b0, cnt_r};
  end

  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_found  = out_found_r;
  assign out_length = out_len_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(wb_valid_r && cmd.wr_val))
    else $error("two writes to the store in one cycle");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_valid_r |-> (cmp_idx_r < cnt_r))
    else $error("compare on an entry beyond the count");

endmodule

[rtl/ordered_array_list_engine.sv]
// Each request is decoded first; clear, unused modes and rejected requests then go straight to the result.
// Insert at p shifts the elements from p onward up by one (one element moved per cycle) unless appending.
// Delete at p shifts the elements after p down by one; locate/prior/next scan the list from the front.
// Prior and next then read the neighbor of the first match.
// The engine takes one item at a time: a new input item is accepted only in the idle state.
// Reset (rst_n low, synchronous) empties the list and drops any pending result; the store is kept.
`timescale 1ns / 1ps

module ordered_array_list_engine
  import oal_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  oal_in_if.sink    in_ch,
  oal_out_if.source out_ch
);

  localparam int unsigned POS_W = $clog2(CAPACITY + 1);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;

  oal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  oal_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mode     (in_ch.mode),
    .in_position (in_ch.position[POS_W-1:0]),
    .in_value    (in_ch.value),
    .cmd         (cmd),
    .stat        (stat),
    .out_status  (out_ch.status),
    .out_data    (out_ch.data_out),
    .out_found   (out_ch.found_position[POS_W-1:0]),
    .out_length  (out_ch.list_length[POS_W-1:0])
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

[sim/oal_list_checker.sv]
`timescale 1ns / 1ps

module oal_list_checker
  import oal_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  oal_in_if    in_ch,
  oal_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   list_len
);

  typedef struct {
    status_t                   status;
    logic signed [VALUE_W-1:0] data;
    logic [6:0]                found;
    logic [6:0]                len;
  } list_result_t;

  logic signed [VALUE_W-1:0] list_mem [CAPACITY_DEF];
  int                        list_count = 0;
  int                        errors     = 0;
  int                        waiting    = 0;
  list_result_t              result_q[$];
  list_result_t              want;

  assign fail_count = errors;
  assign pending    = waiting;
  assign list_len   = list_count;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 50) begin
      $display("%0t ERROR: %s", $time, msg);
    end
  endtask

  function automatic int first_hit(logic signed [VALUE_W-1:0] v);
    for (int k = 0; k < list_count; k++) begin
      if (list_mem[k] == v) begin
        return k + 1;
      end
    end
    return 0;
  endfunction

  function automatic list_result_t apply_request(logic [MODE_W-1:0] m, int p,
                                                 logic signed [VALUE_W-1:0] v);
    list_result_t r;
    int           hit;
    r.status = ST_OK;
    r.data   = '0;
    r.found  = '0;
    case (m)
      MODE_INSERT: begin
        if (p < 1 || p > list_count + 1) begin
          r.status = ST_BADPOS;
        end else if (list_count >= CAPACITY_DEF) begin
          r.status = ST_FULL;
        end else begin
          for (int k = list_count; k >= p; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = v;
          list_count++;
        end
      end
      MODE_DELETE: begin
        if (p < 1 || p > list_count) begin
          r.status = ST_BADPOS;
        end else begin
          r.data = list_mem[p-1];
          for (int k = p; k < list_count; k++) list_mem[k-1] = list_mem[k];
          list_count--;
        end
      end
      MODE_GET: begin
        if (p < 1 || p > list_count) r.status = ST_BADPOS;
        else r.data = list_mem[p-1];
      end
      MODE_LOCATE: begin
        hit     = first_hit(v);
        r.found = hit[6:0];
        if (hit == 0) r.status = ST_NOTFOUND;
      end
      MODE_PRIOR: begin
        hit     = first_hit(v);
        r.found = hit[6:0];
        if (hit <= 1) r.status = ST_NOTFOUND;
        else r.data = list_mem[hit-2];
      end
      MODE_NEXT: begin
        hit     = first_hit(v);
        r.found = hit[6:0];
        if (hit == 0 || hit >= list_count) r.status = ST_NOTFOUND;
        else r.data = list_mem[hit];
      end
      MODE_CLEAR: begin
        list_count = 0;
      end
      default: begin
      end
    endcase
    r.len = list_count[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      list_count = 0;
      result_q.delete();
      waiting = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result item with no request outstanding");
        end else begin
          want = result_q.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_ch.status, want.status));
          if (out_ch.data_out !== want.data)
            report_mismatch($sformatf("data_out got %0d expected %0d",
                                      out_ch.data_out, want.data));
          if (out_ch.found_position !== want.found)
            report_mismatch($sformatf("found_position got %0d expected %0d",
                                      out_ch.found_position, want.found));
          if (out_ch.list_length !== want.len)
            report_mismatch($sformatf("list_length got %0d expected %0d",
                                      out_ch.list_length, want.len));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        result_q.push_back(apply_request(in_ch.mode, int'(in_ch.position), in_ch.value));
      end
      waiting = result_q.size();
    end
  end

endmodule

[sim/tb_ordered_array_list_engine.sv]
`timescale 1ns / 1ps

module tb_ordered_array_list_engine;
  import oal_pkg::*;

  localparam int                RUN_ITEMS   = 1500;
  localparam int                HOLD_CYCLES = 300;
  localparam int                HOLD_AT     = 400;
  localparam int                TAIL_CYCLES = 80;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  oal_in_if  in_ch ();
  oal_out_if out_ch ();

  int fail_count;
  int pending;
  int list_len;
  int sent  = 0;
  int taken = 0;
  bit steady = 1'b0;

  logic signed [VALUE_W-1:0] pool [12];

  ordered_array_list_engine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  oal_list_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .list_len   (list_len)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // called and returns at a falling edge; valid stays high for back-to-back items
  task automatic send_item(input logic [MODE_W-1:0] m, input logic [6:0] p,
                           input logic signed [VALUE_W-1:0] v);
    int gap;
    if (sent % 64 == 0) steady = ($urandom_range(0, 3) == 0);
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.mode     = m;
    in_ch.position = p;
    in_ch.value    = v;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return pool[$urandom_range(0, 11)];
  endfunction

  function automatic logic [6:0] pick_pos(int span);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 7'd0;
    if (r == 1) return (span + 1 > 127) ? 7'd127 : 7'(span + 1);
    if (r == 2) return 7'($urandom_range(0, 127));
    if (span == 0) return 7'd1;
    return 7'($urandom_range(1, span));
  endfunction

  task automatic fill_list(input int target);
    while (list_len < target)
      send_item(MODE_INSERT, 7'($urandom_range(1, list_len + 1)), pick_value());
  endtask

  task automatic drain_list();
    while (list_len > 0)
      send_item(MODE_DELETE, 7'($urandom_range(1, list_len)), $urandom);
  endtask

  task automatic mixed_ops(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 39);
      if (r < 10) send_item(MODE_INSERT, pick_pos(list_len + 1), pick_value());
      else if (r < 15) send_item(MODE_DELETE, pick_pos(list_len), $urandom);
      else if (r < 21) send_item(MODE_GET, pick_pos(list_len), $urandom);
      else if (r < 27) send_item(MODE_LOCATE, 7'($urandom), pick_value());
      else if (r < 32) send_item(MODE_PRIOR, 7'($urandom), pick_value());
      else if (r < 37) send_item(MODE_NEXT, 7'($urandom), pick_value());
      else if (r < 38) send_item(MODE_CLEAR, 7'($urandom), $urandom);
      else send_item(MODE_UNUSED, 7'($urandom), $urandom);
    end
  endtask

  task automatic noise_ops(input int n);
    repeat (n) send_item(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)), $urandom);
  endtask

  initial begin : receiver
    int gap;
    bit calm;
    calm = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 7);
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_INSERT;
    in_ch.position = '0;
    in_ch.value    = '0;
    pool[0] = 32'sh0000_0000;
    pool[1] = -32'sd1;
    pool[2] = 32'sh7FFF_FFFF;
    pool[3] = 32'sh8000_0000;
    for (int k = 4; k < 12; k++) pool[k] = $urandom;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty list corner cases
    send_item(MODE_GET,    7'd1, 32'sd0);
    send_item(MODE_DELETE, 7'd0, 32'sd0);
    send_item(MODE_LOCATE, 7'd0, 32'sd0);
    send_item(MODE_PRIOR,  7'd0, 32'sd0);
    send_item(MODE_NEXT,   7'd0, 32'sd0);
    send_item(MODE_UNUSED, 7'd0, 32'sd0);
    send_item(MODE_INSERT, 7'd0, 32'sd5);
    send_item(MODE_INSERT, 7'd2, 32'sd5);
    // build [0, max, min, -1]
    send_item(MODE_INSERT, 7'd1, pool[2]);
    send_item(MODE_INSERT, 7'd2, pool[3]);
    send_item(MODE_INSERT, 7'd1, pool[0]);
    send_item(MODE_INSERT, 7'd4, pool[1]);
    send_item(MODE_INSERT, 7'd127, 32'sd7);
    send_item(MODE_GET,    7'd4, 32'sd0);
    send_item(MODE_GET,    7'd5, 32'sd0);
    send_item(MODE_LOCATE, 7'd0, pool[2]);
    send_item(MODE_PRIOR,  7'd0, pool[0]);
    send_item(MODE_PRIOR,  7'd0, pool[3]);
    send_item(MODE_NEXT,   7'd0, pool[1]);
    send_item(MODE_NEXT,   7'd0, pool[0]);
    send_item(MODE_LOCATE, 7'd0, 32'sd12345);
    send_item(MODE_DELETE, 7'd2, 32'sd0);
    send_item(MODE_DELETE, 7'd127, 32'sd0);
    send_item(MODE_UNUSED, 7'd127, 32'sd0);
    send_item(MODE_CLEAR,  7'd0, 32'sd0);
    send_item(MODE_GET,    7'd1, 32'sd0);

    wait_drained();

    while (sent < RUN_ITEMS) begin
      if ($urandom_range(0, 7) == 0) wait_drained();
      case ($urandom_range(0, 9))
        0, 1: fill_list($urandom_range(1, 64));
        2: begin
          fill_list(64);
          send_item(MODE_INSERT, 7'($urandom_range(1, 65)), pick_value());
          send_item(MODE_INSERT, 7'd66, pick_value());
          send_item(MODE_NEXT, 7'd0, pick_value());
          send_item(MODE_GET, 7'd64, 32'sd0);
        end
        3: drain_list();
        8: noise_ops($urandom_range(5, 20));
        9: send_item(MODE_CLEAR, 7'($urandom), $urandom);
        default: mixed_ops($urandom_range(10, 60));
      endcase
    end

    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** ordered_array_list_engine: PASSED **");
    end else begin
      $display("** ordered_array_list_engine: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("timeout: sent %0d, results %0d, outstanding %0d", sent, taken, pending);
    $display("** ordered_array_list_engine: FAILED **");
    $finish;
  end

endmodule
